// File: hw/rtl/abst_pkg.sv
// Shared types and codes for the array binary search tree block.
package abst_pkg;

    localparam int KEY_W  = 32;
    localparam int SLOT_W = 6;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    // Request class decided at the front, before the tree is touched.
    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_LOOKUP = 2'd1,
        K_REJECT = 2'd2,
        K_MISS   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [KEY_W-1:0]   key;
        logic signed [KEY_W-1:0]   payload;
    } t_cmd;

    typedef struct packed {
        t_status                   status;
        logic signed [KEY_W-1:0]   value;
        logic [SLOT_W-1:0]         slot;
    } t_result;

endpackage

// File: hw/rtl/abst_fifo.sv
// Two-entry first-in first-out queue of fixed-width words.
module abst_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// File: hw/rtl/abst_front.sv
// Front end: takes request words, classifies them and queues them for the walker.
module abst_front
    import abst_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_hold,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic                    i_op,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic signed [KEY_W-1:0] i_payload,
    output t_cmd                    o_cmd,
    output logic                    o_cmd_valid,
    input  logic                    i_cmd_take
);

    t_cmd                  cmd_in;
    logic                  q_full;
    logic                  q_empty;
    logic [$bits(t_cmd)-1:0] q_rdata;

    // Key zero never reaches the tree: an insert of it is refused and a
    // lookup of it misses.
    always_comb begin
        cmd_in.key     = i_key;
        cmd_in.payload = i_payload;
        if (i_op) begin
            cmd_in.kind = (i_key == '0) ? K_MISS : K_LOOKUP;
        end else begin
            cmd_in.kind = (i_key == '0) ? K_REJECT : K_INSERT;
        end
    end

    assign o_full = q_full || i_hold;

    abst_fifo #(
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_wdata (cmd_in),
        .o_full  (q_full),
        .i_pop   (i_cmd_take),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign o_cmd       = t_cmd'(q_rdata);
    assign o_cmd_valid = !q_empty;

endmodule

// File: hw/rtl/abst_back.sv
// Back end: tree walker over the key and value memories, with a result queue.
module abst_back
    import abst_pkg::*;
#(
    parameter int NODES = 63
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_cmd_valid,
    output logic    o_cmd_take,
    output logic    o_clearing,
    output t_result o_res,
    output logic    o_res_empty,
    input  logic    i_res_pop
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int NW = IW + 1;
    localparam int CW = $clog2(NODES + 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    logic signed [KEY_W-1:0] mem_keys [NODES];
    logic signed [KEY_W-1:0] mem_vals [NODES];

    t_state                  r_state, n_state;
    logic [IW-1:0]           r_idx, n_idx;
    logic [IW-1:0]           r_clr, n_clr;
    logic [CW-1:0]           r_count, n_count;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic signed [KEY_W-1:0] r_payload, n_payload;
    logic                    r_lookup, n_lookup;
    t_result                 r_res, n_res;
    logic signed [KEY_W-1:0] r_rd_key;
    logic signed [KEY_W-1:0] r_rd_val;

    logic                    key_we;
    logic                    val_we;
    logic [IW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] key_wd;
    logic signed [KEY_W-1:0] val_wd;
    logic                    gt;
    logic                    eq;
    logic [NW-1:0]           nxt;
    logic                    nxt_out;
    logic                    res_full;
    logic                    res_push;
    logic [$bits(t_result)-1:0] res_rdata;

    assign gt      = r_key > r_rd_key;
    assign eq      = r_key == r_rd_key;
    assign nxt     = {r_idx, 1'b0} + (gt ? NW'(2) : NW'(1));
    assign nxt_out = nxt >= NW'(NODES);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_clr      = r_clr;
        n_count    = r_count;
        n_key      = r_key;
        n_payload  = r_payload;
        n_lookup   = r_lookup;
        n_res      = r_res;
        key_we     = 1'b0;
        val_we     = 1'b0;
        wr_addr    = r_idx;
        key_wd     = r_key;
        val_wd     = r_payload;
        o_cmd_take = 1'b0;
        res_push   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                key_we  = 1'b1;
                wr_addr = r_clr;
                key_wd  = '0;
                if (r_clr == IW'(NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + IW'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_key      = i_cmd.key;
                    n_payload  = i_cmd.payload;
                    n_lookup   = (i_cmd.kind == K_LOOKUP);
                    n_idx      = '0;
                    n_res      = '{status: ST_FULL, value: '0, slot: '0};
                    case (i_cmd.kind)
                        K_REJECT: begin
                            n_state = S_EMIT;
                        end
                        K_MISS: begin
                            n_res.status = ST_NOT_FOUND;
                            n_state      = S_EMIT;
                        end
                        K_LOOKUP: begin
                            n_state = S_WALK;
                        end
                        K_INSERT: begin
                            if (r_count >= CW'(NODES)) begin
                                n_state = S_EMIT;
                            end else if (r_count == '0) begin
                                // Empty tree: the pair becomes the root.
                                key_we       = 1'b1;
                                val_we       = 1'b1;
                                wr_addr      = '0;
                                key_wd       = i_cmd.key;
                                val_wd       = i_cmd.payload;
                                n_count      = CW'(1);
                                n_res.status = ST_INSERTED;
                                n_state      = S_EMIT;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // r_rd_key holds the key stored at r_idx.
                n_res = '{status: ST_NOT_FOUND, value: '0, slot: '0};
                if (r_rd_key == '0) begin
                    n_state = S_EMIT;
                    if (!r_lookup) begin
                        key_we       = 1'b1;
                        val_we       = 1'b1;
                        n_count      = r_count + CW'(1);
                        n_res.status = ST_INSERTED;
                        n_res.slot   = SLOT_W'(r_idx);
                    end
                end else if (eq) begin
                    n_state    = S_EMIT;
                    n_res.slot = SLOT_W'(r_idx);
                    if (r_lookup) begin
                        n_res.status = ST_FOUND;
                        n_res.value  = r_rd_val;
                    end else begin
                        val_we       = 1'b1;
                        n_res.status = ST_UPDATED;
                    end
                end else if (nxt_out) begin
                    n_state      = S_EMIT;
                    n_res.status = r_lookup ? ST_NOT_FOUND : ST_FULL;
                end else begin
                    n_idx = nxt[IW-1:0];
                end
            end
            S_EMIT: begin
                if (!res_full) begin
                    res_push = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
        r_lookup  <= n_lookup;
        r_res     <= n_res;
    end

    // One read port addressed by the next walk index, one write port.
    always_ff @(posedge i_clk) begin
        r_rd_key <= mem_keys[n_idx];
        r_rd_val <= mem_vals[n_idx];
        if (key_we) begin
            mem_keys[wr_addr] <= key_wd;
        end
        if (val_we) begin
            mem_vals[wr_addr] <= val_wd;
        end
    end

    assign o_clearing = (r_state == S_CLEAR);

    abst_fifo #(
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (r_res),
        .o_full  (res_full),
        .i_pop   (i_res_pop),
        .o_rdata (res_rdata),
        .o_empty (o_res_empty)
    );

    assign o_res = t_result'(res_rdata);

endmodule

// File: hw/rtl/array_bst_insert_lookup_top.sv
// The walker takes one word at a time and visits up to clog2(NODES+1) tree levels,
// doing one key memory read per level; the front end queues further words meanwhile.
// Reset: synchronous; afterwards full stays high while the key memory is cleared
// one slot per cycle.
module array_bst_insert_lookup_top
    import abst_pkg::*;
#(
    parameter int NODES = 63
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic                     i_op,
    input  logic signed [KEY_W-1:0]  i_key,
    input  logic signed [KEY_W-1:0]  i_payload,
    output logic                     empty,
    input  logic                     pop,
    output logic [2:0]               o_status,
    output logic signed [KEY_W-1:0]  o_found_value,
    output logic [SLOT_W-1:0]        o_slot
);

    t_cmd    cmd;
    logic    cmd_valid;
    logic    cmd_take;
    logic    clearing;
    t_result res;

    // The front end classifies each word (key zero is settled there) and
    // holds up to two of them, so requests keep arriving while the walker
    // is busy. It refuses words while the key memory is being cleared.
    abst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_payload   (i_payload),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take)
    );

    // The back end walks the tree one level per cycle and posts each result
    // word into its own two-entry queue, which drives the result ports.
    abst_back #(
        .NODES (NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_take  (cmd_take),
        .o_clearing  (clearing),
        .o_res       (res),
        .o_res_empty (empty),
        .i_res_pop   (pop)
    );

    assign o_status      = res.status;
    assign o_found_value = res.value;
    assign o_slot        = res.slot;

    // Only a found word carries a value.
    a_value_only_when_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_FOUND) |-> (o_found_value == '0))
        else $error("result value nonzero for a status other than found");

    // Refused and missed words carry no slot.
    a_slot_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ST_FULL || o_status == ST_NOT_FOUND)) |-> (o_slot == '0))
        else $error("slot nonzero for a full or not found result");

    // Leaving reset starts the clearing pass, during which no word is taken.
    a_full_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> full)
        else $error("input accepted at the start of the clearing pass");

endmodule
